// ===== rtl/aodf_pkg.sv =====
// Shared types, constants and helper functions for the obstacle-avoid drive controller.
package aodf_pkg;

   localparam int DIST_BITS  = 12;
   localparam int LIMIT_BITS = 12;
   localparam int CMP_BITS   = (DIST_BITS > LIMIT_BITS) ? DIST_BITS : LIMIT_BITS;
   localparam int WAIT_BITS  = 16;
   localparam int SPEED_BITS = 7;
   localparam int WHEEL_BITS = 8;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [SPEED_BITS-1:0] SPEED_MAX = SPEED_BITS'(100);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_WAIT_TICKS      = 3'd0,
      CSR_FRONT_LIMIT     = 3'd1,
      CSR_SIDE_LIMIT      = 3'd2,
      CSR_OUTER_LIMIT     = 3'd3,
      CSR_CRUISE_SPEED    = 3'd4,
      CSR_SLOW_TURN_SPEED = 3'd5,
      CSR_WIDE_TURN_SPEED = 3'd6,
      CSR_SPIN_SPEED      = 3'd7
   } csr_idx_type;

   localparam logic [WAIT_BITS-1:0]  RST_WAIT_TICKS      = 16'd1000;
   localparam logic [LIMIT_BITS-1:0] RST_FRONT_LIMIT     = 12'd320;
   localparam logic [LIMIT_BITS-1:0] RST_SIDE_LIMIT      = 12'd480;
   localparam logic [LIMIT_BITS-1:0] RST_OUTER_LIMIT     = 12'd640;
   localparam logic [SPEED_BITS-1:0] RST_CRUISE_SPEED    = 7'd25;
   localparam logic [SPEED_BITS-1:0] RST_SLOW_TURN_SPEED = 7'd10;
   localparam logic [SPEED_BITS-1:0] RST_WIDE_TURN_SPEED = 7'd20;
   localparam logic [SPEED_BITS-1:0] RST_SPIN_SPEED      = 7'd15;

   typedef struct packed {
      logic [WAIT_BITS-1:0]  wait_ticks;
      logic [LIMIT_BITS-1:0] front_limit;
      logic [LIMIT_BITS-1:0] side_limit;
      logic [LIMIT_BITS-1:0] outer_limit;
      logic [SPEED_BITS-1:0] cruise_speed;
      logic [SPEED_BITS-1:0] slow_turn_speed;
      logic [SPEED_BITS-1:0] wide_turn_speed;
      logic [SPEED_BITS-1:0] spin_speed;
   } cfg_type;

   typedef enum logic [3:0] {
      MODE_WAIT_START   = 4'd0,
      MODE_WAITING      = 4'd1,
      MODE_FORWARD      = 4'd2,
      MODE_FORWARD_RUN  = 4'd3,
      MODE_LEFT         = 4'd4,
      MODE_LEFT_RUN     = 4'd5,
      MODE_RIGHT        = 4'd6,
      MODE_RIGHT_RUN    = 4'd7,
      MODE_CL_TURN      = 4'd8,
      MODE_CL_TURN_RUN  = 4'd9,
      MODE_CR_TURN      = 4'd10,
      MODE_CR_TURN_RUN  = 4'd11,
      MODE_SPIN_L       = 4'd12,
      MODE_SPIN_L_RUN   = 4'd13,
      MODE_SPIN_R       = 4'd14,
      MODE_SPIN_R_RUN   = 4'd15
   } mode_type;

   typedef enum logic [2:0] {
      CLS_NONE         = 3'd0,
      CLS_CENTER_RIGHT = 3'd1,
      CLS_CENTER_LEFT  = 3'd2,
      CLS_FRONT        = 3'd3,
      CLS_RIGHT        = 3'd4,
      CLS_LEFT         = 3'd5
   } cls_type;

   typedef struct packed {
      mode_type                      mode;
      logic [WAIT_BITS-1:0]          wait_cnt;
      logic signed [WHEEL_BITS-1:0]  right_cmd;
      logic signed [WHEEL_BITS-1:0]  left_cmd;
   } state_type;

   // Maneuver start mode for each obstacle class.
   function automatic mode_type class_target(input cls_type cls);
      mode_type m;
      begin
         unique case (cls)
            CLS_CENTER_RIGHT: m = MODE_CL_TURN;
            CLS_CENTER_LEFT:  m = MODE_CR_TURN;
            CLS_FRONT:        m = MODE_SPIN_L;
            CLS_RIGHT:        m = MODE_LEFT;
            CLS_LEFT:         m = MODE_RIGHT;
            default:          m = MODE_FORWARD;
         endcase
         return m;
      end
   endfunction

   // Clamp a speed register to 100 percent and widen to wheel format.
   function automatic logic signed [WHEEL_BITS-1:0] sat_speed(input logic [SPEED_BITS-1:0] v);
      logic [SPEED_BITS-1:0] s;
      begin
         s = (v > SPEED_MAX) ? SPEED_MAX : v;
         return $signed(WHEEL_BITS'(s));
      end
   endfunction

endpackage

// ===== rtl/aodf_csr.sv =====
// Configuration register file for the obstacle-avoid drive controller.
module aodf_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [aodf_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [aodf_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output aodf_pkg::cfg_type                    cfg
);
   import aodf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_WAIT_TICKS:      cfg_in.wait_ticks      = csr_wdata[WAIT_BITS-1:0];
            CSR_FRONT_LIMIT:     cfg_in.front_limit     = csr_wdata[LIMIT_BITS-1:0];
            CSR_SIDE_LIMIT:      cfg_in.side_limit      = csr_wdata[LIMIT_BITS-1:0];
            CSR_OUTER_LIMIT:     cfg_in.outer_limit     = csr_wdata[LIMIT_BITS-1:0];
            CSR_CRUISE_SPEED:    cfg_in.cruise_speed    = csr_wdata[SPEED_BITS-1:0];
            CSR_SLOW_TURN_SPEED: cfg_in.slow_turn_speed = csr_wdata[SPEED_BITS-1:0];
            CSR_WIDE_TURN_SPEED: cfg_in.wide_turn_speed = csr_wdata[SPEED_BITS-1:0];
            CSR_SPIN_SPEED:      cfg_in.spin_speed      = csr_wdata[SPEED_BITS-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wait_ticks      <= RST_WAIT_TICKS;
         cfg_ff.front_limit     <= RST_FRONT_LIMIT;
         cfg_ff.side_limit      <= RST_SIDE_LIMIT;
         cfg_ff.outer_limit     <= RST_OUTER_LIMIT;
         cfg_ff.cruise_speed    <= RST_CRUISE_SPEED;
         cfg_ff.slow_turn_speed <= RST_SLOW_TURN_SPEED;
         cfg_ff.wide_turn_speed <= RST_WIDE_TURN_SPEED;
         cfg_ff.spin_speed      <= RST_SPIN_SPEED;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/aodf_classify.sv =====
// Obstacle classifier: strict threshold tests on five distances in priority order.
module aodf_classify (
   input  logic [aodf_pkg::DIST_BITS-1:0] dist_right,
   input  logic [aodf_pkg::DIST_BITS-1:0] dist_center_right,
   input  logic [aodf_pkg::DIST_BITS-1:0] dist_center,
   input  logic [aodf_pkg::DIST_BITS-1:0] dist_center_left,
   input  logic [aodf_pkg::DIST_BITS-1:0] dist_left,
   input  aodf_pkg::cfg_type              cfg,
   output aodf_pkg::cls_type              cls
);
   import aodf_pkg::*;

   logic [CMP_BITS-1:0] r, cr, c, cl, l, fl, sl, ol;
   logic hit_cr, hit_cl, hit_front, hit_clear, hit_right, hit_left;

   always_comb begin
      r  = CMP_BITS'(dist_right);
      cr = CMP_BITS'(dist_center_right);
      c  = CMP_BITS'(dist_center);
      cl = CMP_BITS'(dist_center_left);
      l  = CMP_BITS'(dist_left);
      fl = CMP_BITS'(cfg.front_limit);
      sl = CMP_BITS'(cfg.side_limit);
      ol = CMP_BITS'(cfg.outer_limit);

      hit_cr    = (cr < sl || r < ol) && c > fl && cl > sl && l > sl;
      hit_cl    = cr > sl && r > sl && c > fl && (cl < sl || l < ol);
      hit_front = c < fl;
      hit_clear = cr > sl && c > fl && cl > sl && r > sl && l > sl;
      hit_right = r < sl && cr > sl && c > fl && cl > sl && l > sl;
      hit_left  = r > sl && cr > sl && c > fl && cl > sl && l < sl;

      // first match wins; a clear path outranks the single-side tests
      if (hit_cr)         cls = CLS_CENTER_RIGHT;
      else if (hit_cl)    cls = CLS_CENTER_LEFT;
      else if (hit_front) cls = CLS_FRONT;
      else if (hit_clear) cls = CLS_NONE;
      else if (hit_right) cls = CLS_RIGHT;
      else if (hit_left)  cls = CLS_LEFT;
      else                cls = CLS_NONE;
   end

endmodule

// ===== rtl/aodf_mode_step.sv =====
// Drive mode machine: next mode, wait counter and wheel commands for one tick.
module aodf_mode_step (
   input  aodf_pkg::state_type cur,
   input  aodf_pkg::cfg_type   cfg,
   input  aodf_pkg::cls_type   cls,
   output aodf_pkg::state_type nxt,
   output aodf_pkg::cls_type   cls_out
);
   import aodf_pkg::*;

   logic [WAIT_BITS-1:0]         wait_inc;
   logic                         wait_done;
   mode_type                     target;
   logic                         is_run;
   mode_type                     mode_in;
   logic [WAIT_BITS-1:0]         wait_in;
   logic signed [WHEEL_BITS-1:0] right_in;
   logic signed [WHEEL_BITS-1:0] left_in;

   assign wait_inc  = (&cur.wait_cnt) ? cur.wait_cnt : cur.wait_cnt + WAIT_BITS'(1);
   assign wait_done = wait_inc > cfg.wait_ticks;
   assign target    = class_target(cls);
   // in-progress maneuver modes, all odd codes but the waiting mode
   assign is_run    = cur.mode[0] && (cur.mode != MODE_WAITING);

   // next state
   always_comb begin
      mode_in = cur.mode;
      wait_in = wait_inc;
      unique case (cur.mode)
         MODE_WAIT_START: begin
            // counter restarts here, so the wait cannot end on this tick
            wait_in = '0;
            mode_in = MODE_WAITING;
         end
         MODE_WAITING: begin
            if (wait_done) mode_in = MODE_FORWARD;
         end
         MODE_FORWARD: mode_in = MODE_FORWARD_RUN;
         MODE_LEFT:    mode_in = MODE_LEFT_RUN;
         MODE_RIGHT:   mode_in = MODE_RIGHT_RUN;
         MODE_CL_TURN: mode_in = MODE_CL_TURN_RUN;
         MODE_CR_TURN: mode_in = MODE_CR_TURN_RUN;
         MODE_SPIN_L:  mode_in = MODE_SPIN_L_RUN;
         MODE_SPIN_R:  mode_in = MODE_SPIN_R_RUN;
         default: begin
            // restart only for a different maneuver
            if (target != mode_type'({cur.mode[3:1], 1'b0})) mode_in = target;
         end
      endcase
   end

   // outputs: wheel commands and reported class
   always_comb begin
      right_in = cur.right_cmd;
      left_in  = cur.left_cmd;
      cls_out  = is_run ? cls : CLS_NONE;
      unique case (cur.mode)
         MODE_WAIT_START: begin
            right_in = '0;
            left_in  = '0;
         end
         MODE_FORWARD: begin
            right_in = sat_speed(cfg.cruise_speed);
            left_in  = sat_speed(cfg.cruise_speed);
         end
         MODE_LEFT: begin
            right_in = sat_speed(cfg.slow_turn_speed);
            left_in  = '0;
         end
         MODE_RIGHT: begin
            right_in = '0;
            left_in  = sat_speed(cfg.slow_turn_speed);
         end
         MODE_CL_TURN: begin
            right_in = sat_speed(cfg.wide_turn_speed);
            left_in  = '0;
         end
         MODE_CR_TURN: begin
            right_in = '0;
            left_in  = sat_speed(cfg.wide_turn_speed);
         end
         MODE_SPIN_L: begin
            right_in = sat_speed(cfg.spin_speed);
            left_in  = -sat_speed(cfg.spin_speed);
         end
         MODE_SPIN_R: begin
            right_in = -sat_speed(cfg.spin_speed);
            left_in  = sat_speed(cfg.spin_speed);
         end
         default: begin
            right_in = cur.right_cmd;
            left_in  = cur.left_cmd;
         end
      endcase
   end

   assign nxt = '{mode: mode_in, wait_cnt: wait_in, right_cmd: right_in, left_cmd: left_in};

endmodule

// ===== rtl/obstacle_avoid_drive_fsm_top.sv =====
// Top level of the obstacle-avoid drive controller: handshake, state registers, assertions.
//
// One req_ transaction is one control tick carrying five rangefinder distances
// (1/16 cm). Each accepted transaction yields exactly one rsp_ transaction with
// the two wheel commands (signed percent), the drive mode after the tick and
// the obstacle class found on that tick (none unless the tick began in a run mode).
// Latency: the response is valid the cycle after the request is accepted.
// Throughput: one transaction per cycle while rsp_ready is high. The classifier and mode
// logic sit in a single combinational pass between the state registers and the response
// register, so req_ready stays high while a response is taken in the same cycle.
// Stall: while rsp_valid is high and rsp_ready low, hold the response and drop
// req_ready; the state does not advance until the response drains.
// Configuration: csr_we writes register csr_index (0 wait_ticks .. 7 spin_speed)
// at the clock edge; write only while the block is idle.
// Reset (synchronous, active high): mode goes to wait start, wait counter and
// wheel commands clear, configuration takes its reset values, no response
// is pending.
module obstacle_avoid_drive_fsm_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [aodf_pkg::DIST_BITS-1:0]       req_dist_right,
   input  logic [aodf_pkg::DIST_BITS-1:0]       req_dist_center_right,
   input  logic [aodf_pkg::DIST_BITS-1:0]       req_dist_center,
   input  logic [aodf_pkg::DIST_BITS-1:0]       req_dist_center_left,
   input  logic [aodf_pkg::DIST_BITS-1:0]       req_dist_left,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [aodf_pkg::WHEEL_BITS-1:0] rsp_right_wheel,
   output logic signed [aodf_pkg::WHEEL_BITS-1:0] rsp_left_wheel,
   output logic [3:0]                           rsp_drive_mode,
   output logic [2:0]                           rsp_obstacle_class,
   input  logic                                 csr_we,
   input  logic [aodf_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [aodf_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import aodf_pkg::*;

   cfg_type   cfg;
   cls_type   cls_raw;
   cls_type   cls_step;
   state_type state_ff;
   state_type state_in;
   cls_type   cls_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      req_fire;

   aodf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   aodf_classify u_classify (
      .dist_right        (req_dist_right),
      .dist_center_right (req_dist_center_right),
      .dist_center       (req_dist_center),
      .dist_center_left  (req_dist_center_left),
      .dist_left         (req_dist_left),
      .cfg               (cfg),
      .cls               (cls_raw)
   );

   aodf_mode_step u_mode_step (
      .cur     (state_ff),
      .cfg     (cfg),
      .cls     (cls_raw),
      .nxt     (state_in),
      .cls_out (cls_step)
   );

   // Accept whenever the response slot is empty or drains this cycle.
   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign req_fire     = req_valid && req_ready;
   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_ready);

   // Controller state; it doubles as the response payload, since it only
   // advances when the previous response is gone.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode      <= MODE_WAIT_START;
         state_ff.wait_cnt  <= '0;
         state_ff.right_cmd <= '0;
         state_ff.left_cmd  <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (req_fire) state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Class is payload only: no reset needed.
   always_ff @(posedge clock) begin
      if (req_fire) cls_ff <= cls_step;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_right_wheel    = state_ff.right_cmd;
   assign rsp_left_wheel     = state_ff.left_cmd;
   assign rsp_drive_mode     = state_ff.mode;
   assign rsp_obstacle_class = cls_ff;

   // A start mode always moves on to an odd mode: its in-progress mode, or waiting after wait start.
   a_start_to_run: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !state_ff.mode[0]) |=> state_ff.mode[0])
      else $error("start mode did not advance to an in-progress mode");

   // The wait start mode restarts the wait counter.
   a_wait_clear: assert property (@(posedge clock) disable iff (reset)
      (req_fire && state_ff.mode == MODE_WAIT_START) |=> state_ff.wait_cnt == '0)
      else $error("wait counter not cleared by wait start");

   // Wheel commands stay within plus or minus 100 percent.
   a_wheel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_right_wheel <= 8'sd100 && rsp_right_wheel >= -8'sd100 &&
                     rsp_left_wheel <= 8'sd100 && rsp_left_wheel >= -8'sd100))
      else $error("wheel command out of range");

   // An empty response slot never blocks the request side.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("request stalled with empty response slot");

endmodule
